// File: sv/ps2mc_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor block.
`timescale 1ns / 1ps

package ps2mc_pkg;

  localparam int REG_BITS = 13;

  typedef enum logic {
    REG_HSIZE = 1'b0,
    REG_VSIZE = 1'b1
  } reg_index_t;

  localparam logic [REG_BITS-1:0] SCREEN_W_RST = 13'd1024;
  localparam logic [REG_BITS-1:0] SCREEN_H_RST = 13'd768;

  // Header byte bit positions.
  localparam int HDR_ALWAYS_ONE = 3;
  localparam int HDR_X_SIGN     = 4;
  localparam int HDR_Y_SIGN     = 5;

  // Position of a byte within a packet.
  localparam logic [1:0] IDX_HEADER = 2'd0;
  localparam logic [1:0] IDX_X_MOVE = 2'd1;
  localparam logic [1:0] IDX_Y_MOVE = 2'd2;

endpackage

// File: sv/ps2_mouse_packet_cursor.sv
// PS/2 mouse packet decoder that moves a cursor clamped to the configured screen.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   data_byte, from_aux
//   out      source     out_valid/out_stall cursor_x, cursor_y, button_bits, delta_x, delta_y
//   cfg      sink       cfg_we              cfg_index, cfg_data
//
// A byte beat is registered, decoded in the following cycle and its result, if any,
// lands in the output register.
// One byte is taken every cycle; the only limit is the single output register.
// A stalled result holds the decode stage only when that stage also has a result to give.
// Reset sets the screen to 1024 by 768, centers the cursor and restarts packet gathering.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor
  import ps2mc_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   data_byte,
  input  logic                         from_aux,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COORD_BITS-1:0]        cursor_x,
  output logic [COORD_BITS-1:0]        cursor_y,
  output logic [2:0]                   button_bits,
  output logic signed [8:0]            delta_x,
  output logic signed [9:0]            delta_y,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [REG_BITS-1:0]          cfg_data
);

  localparam int W = ((COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS) + 2;
  localparam logic [W-1:0] SPAN = W'(1) << COORD_BITS;
  localparam logic [COORD_BITS-1:0] POS_X_RST = COORD_BITS'(SCREEN_W_RST / 2);
  localparam logic [COORD_BITS-1:0] POS_Y_RST = COORD_BITS'(SCREEN_H_RST / 2);

  function automatic logic [COORD_BITS-1:0] clamp_axis(
    input logic [COORD_BITS-1:0] pos,
    input logic signed [9:0]     delta,
    input logic [REG_BITS-1:0]   size
  );
    logic [W-1:0]        lim;
    logic signed [W-1:0] v;
    lim = (size == '0) ? W'(1) : W'(size);
    if (lim > SPAN) begin
      lim = SPAN;
    end
    v = signed'(W'(pos)) + W'(delta);
    if (v < 0) begin
      v = '0;
    end else if (unsigned'(v) >= lim) begin
      v = signed'(lim - W'(1));
    end
    return COORD_BITS'(v);
  endfunction

  logic [REG_BITS-1:0]   hsize;
  logic [REG_BITS-1:0]   vsize;
  logic [1:0]            byte_index;
  logic [7:0]            header_byte;
  logic [7:0]            x_move_byte;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_aux;

  logic                  s1_emit;
  logic                  s1_go;
  logic signed [8:0]     dx_next;
  logic signed [9:0]     dy_next;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;

  // The decode stage gives a result on the third byte of a packet with a good header.
  assign s1_emit = s1_aux && (byte_index != IDX_HEADER) && (byte_index != IDX_X_MOVE) &&
                   header_byte[HDR_ALWAYS_ONE];
  assign s1_go    = !s1_emit || !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_go;

  always_comb begin
    dx_next = signed'({header_byte[HDR_X_SIGN], x_move_byte});
    dy_next = -signed'({2'b00, s1_byte});
    if (header_byte[HDR_Y_SIGN]) begin
      dy_next = dy_next + 10'sd256;
    end
    pos_x_next = clamp_axis(pos_x, 10'(dx_next), hsize);
    pos_y_next = clamp_axis(pos_y, dy_next, vsize);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsize <= SCREEN_W_RST;
      vsize <= SCREEN_H_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_HSIZE: hsize <= cfg_data;
        REG_VSIZE: vsize <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_byte <= data_byte;
      s1_aux  <= from_aux;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= IDX_HEADER;
      header_byte <= '0;
      x_move_byte <= '0;
      pos_x       <= POS_X_RST;
      pos_y       <= POS_Y_RST;
    end else if (s1_valid && s1_go && s1_aux) begin
      case (byte_index)
        IDX_HEADER: begin
          header_byte <= s1_byte;
          byte_index  <= IDX_X_MOVE;
        end
        IDX_X_MOVE: begin
          x_move_byte <= s1_byte;
          byte_index  <= IDX_Y_MOVE;
        end
        default: begin
          byte_index <= IDX_HEADER;
          if (s1_emit) begin
            pos_x <= pos_x_next;
            pos_y <= pos_y_next;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_valid && s1_go && s1_emit) begin
      cursor_x    <= pos_x_next;
      cursor_y    <= pos_y_next;
      button_bits <= header_byte[2:0];
      delta_x     <= dx_next;
      delta_y     <= dy_next;
    end
  end

`ifndef SYNTH
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_go && s1_emit) |=> out_valid)
    else $error("decoded result did not reach the output register");

  a_cursor_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_x == pos_x) && (cursor_y == pos_y))
    else $error("output cursor differs from the kept cursor");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_emit && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_aux) |-> (byte_index != 2'd3))
    else $error("packet byte index out of range");
`endif

endmodule
